FILE: sv/dtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duration text parser package
// Status codes, character codes and the control state record that is shared
// by the character step logic and the top level.
// ----------------------------------------------------------------------------
package dtp_pkg;

   // Default width of numbers and totals, and the fixed width of the result.
   localparam int COUNT_BITS_DEF = 63;
   localparam int TOTAL_W        = 63;

   // Extra bits that hold a value times ten plus a weighted digit.
   localparam int GUARD_BITS = 4;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_CASE  = 8'h20;
   localparam logic [7:0] CH_H     = 8'h68;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_S     = 8'h73;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_EXPECT_NUM = 3'd2,
      ST_RANGE      = 3'd3,
      ST_UNIT       = 3'd4,
      ST_OVERFLOW   = 3'd5
   } status_type;

   typedef struct packed {
      logic       in_digits;
      logic       seen_token;
      status_type status;
   } parse_ctrl_type;

endpackage

FILE: sv/dtp_char_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duration text parser character step
// Next parser state for one character: digit accumulation with range check,
// token end with a weighted add to the running total, and error capture.
// ----------------------------------------------------------------------------
module dtp_char_step #(
   parameter int COUNT_BITS = dtp_pkg::COUNT_BITS_DEF
) (
   input  logic                    take,
   input  logic [7:0]              ch,
   input  dtp_pkg::parse_ctrl_type ctrl_cur,
   input  logic [COUNT_BITS-1:0]   num_cur,
   input  logic [COUNT_BITS-1:0]   num60_cur,
   input  logic                    ovf60_cur,
   input  logic [COUNT_BITS-1:0]   num3600_cur,
   input  logic                    ovf3600_cur,
   input  logic [COUNT_BITS-1:0]   total_cur,
   output dtp_pkg::parse_ctrl_type ctrl_nxt,
   output logic [COUNT_BITS-1:0]   num_nxt,
   output logic [COUNT_BITS-1:0]   num60_nxt,
   output logic                    ovf60_nxt,
   output logic [COUNT_BITS-1:0]   num3600_nxt,
   output logic                    ovf3600_nxt,
   output logic [COUNT_BITS-1:0]   total_nxt
);

   localparam int W  = COUNT_BITS;
   localparam int XW = COUNT_BITS + dtp_pkg::GUARD_BITS;

   logic          is_digit;
   logic          is_blank;
   logic [7:0]    lower;
   logic [3:0]    digit;
   logic [W-1:0]  base_num;
   logic [W-1:0]  base60;
   logic [W-1:0]  base3600;
   logic          base_ovf60;
   logic          base_ovf3600;
   logic [XW-1:0] cand_num;
   logic [XW-1:0] cand60;
   logic [XW-1:0] cand3600;
   logic [W-1:0]  add_val;
   logic          add_ovf;
   logic [W:0]    add_sum;

   assign is_digit = (ch >= dtp_pkg::CH_ZERO) && (ch <= dtp_pkg::CH_NINE);
   assign is_blank = (ch == dtp_pkg::CH_SPACE) ||
                     ((ch >= dtp_pkg::CH_TAB) && (ch <= dtp_pkg::CH_CR));
   assign lower    = ((ch >= dtp_pkg::CH_UP_A) && (ch <= dtp_pkg::CH_UP_Z)) ?
                     (ch | dtp_pkg::CH_CASE) : ch;
   assign digit    = 4'(ch - dtp_pkg::CH_ZERO);

   // A new token starts from zero; the scaled copies follow the number so that
   // a token end needs only one add.
   assign base_num     = ctrl_cur.in_digits ? num_cur     : '0;
   assign base60       = ctrl_cur.in_digits ? num60_cur   : '0;
   assign base3600     = ctrl_cur.in_digits ? num3600_cur : '0;
   assign base_ovf60   = ctrl_cur.in_digits & ovf60_cur;
   assign base_ovf3600 = ctrl_cur.in_digits & ovf3600_cur;

   assign cand_num = (XW'(base_num) << 3) + (XW'(base_num) << 1) + XW'(digit);
   assign cand60   = (XW'(base60) << 3) + (XW'(base60) << 1) + XW'(digit) * XW'(60);
   assign cand3600 = (XW'(base3600) << 3) + (XW'(base3600) << 1) +
                     XW'(digit) * XW'(3600);

   always_comb begin
      if (is_blank || (lower == dtp_pkg::CH_M)) begin
         add_val = num60_cur;
         add_ovf = ovf60_cur;
      end else if (lower == dtp_pkg::CH_H) begin
         add_val = num3600_cur;
         add_ovf = ovf3600_cur;
      end else begin
         add_val = num_cur;
         add_ovf = 1'b0;
      end
   end

   assign add_sum = {1'b0, total_cur} + {1'b0, add_val};

   always_comb begin
      ctrl_nxt    = ctrl_cur;
      num_nxt     = num_cur;
      num60_nxt   = num60_cur;
      ovf60_nxt   = ovf60_cur;
      num3600_nxt = num3600_cur;
      ovf3600_nxt = ovf3600_cur;
      total_nxt   = total_cur;
      if (take) begin
         if (is_digit) begin
            ctrl_nxt.in_digits  = 1'b1;
            ctrl_nxt.seen_token = 1'b1;
            if (cand_num[XW-1:W] != '0) begin
               ctrl_nxt.status = dtp_pkg::ST_RANGE;
            end else begin
               num_nxt     = cand_num[W-1:0];
               num60_nxt   = cand60[W-1:0];
               ovf60_nxt   = base_ovf60 | (cand60[XW-1:W] != '0);
               num3600_nxt = cand3600[W-1:0];
               ovf3600_nxt = base_ovf3600 | (cand3600[XW-1:W] != '0);
            end
         end else if (!ctrl_cur.in_digits) begin
            if (!is_blank) begin
               ctrl_nxt.status = dtp_pkg::ST_EXPECT_NUM;
            end
         end else begin
            ctrl_nxt.in_digits = 1'b0;
            if (!is_blank && (lower != dtp_pkg::CH_H) && (lower != dtp_pkg::CH_M) &&
                (lower != dtp_pkg::CH_S)) begin
               ctrl_nxt.status = dtp_pkg::ST_UNIT;
            end else if (add_ovf || add_sum[W]) begin
               ctrl_nxt.status = dtp_pkg::ST_OVERFLOW;
            end else begin
               total_nxt = add_sum[W-1:0];
            end
         end
      end
   end

endmodule

FILE: sv/duration_text_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duration text parser
// Sums a whitespace separated duration string (digits with an optional h, m
// or s unit) into seconds and reports the total and a status at the string end.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while req_tready is high; a stalled
// response that fills the finalize stage drops req_tready. The transfer that
// ends the string loads one finalize stage, then the result register.
// Reset: synchronous, clears the parser control state, the total and the valid
// flags of both output stages; the block is ready once reset is released.
// ----------------------------------------------------------------------------
module duration_text_parser #(
   parameter int COUNT_BITS = dtp_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tuser,   // [0] has_char
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [62:0] total_seconds, [63] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   localparam int W  = COUNT_BITS;
   localparam int TW = dtp_pkg::TOTAL_W;

   dtp_pkg::parse_ctrl_type ctrl_ff, ctrl_in, ctrl_step;
   logic [W-1:0] num_ff, num_in, num_step;
   logic [W-1:0] num60_ff, num60_in, num60_step;
   logic         ovf60_ff, ovf60_in, ovf60_step;
   logic [W-1:0] num3600_ff, num3600_in, num3600_step;
   logic         ovf3600_ff, ovf3600_in, ovf3600_step;
   logic [W-1:0] total_ff, total_in, total_step;

   dtp_pkg::parse_ctrl_type fin_ctrl_ff, fin_ctrl_in;
   logic         fin_valid_ff, fin_valid_in;
   logic [W-1:0] fin_total_ff, fin_total_in;
   logic [W-1:0] fin_num60_ff, fin_num60_in;
   logic         fin_ovf60_ff, fin_ovf60_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]       rsp_total_ff, rsp_total_in;
   dtp_pkg::status_type rsp_status_ff, rsp_status_in;

   logic                accept;
   logic                fin_adv;
   logic                take;
   logic [W:0]          fin_sum;
   dtp_pkg::status_type fin_status;
   logic [W-1:0]        fin_total;

   assign fin_adv    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !fin_valid_ff || fin_adv;
   assign accept     = req_tvalid && req_tready;
   assign take       = req_tuser && (ctrl_ff.status == dtp_pkg::ST_OK);

   dtp_char_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .take        (take),
      .ch          (req_tdata),
      .ctrl_cur    (ctrl_ff),
      .num_cur     (num_ff),
      .num60_cur   (num60_ff),
      .ovf60_cur   (ovf60_ff),
      .num3600_cur (num3600_ff),
      .ovf3600_cur (ovf3600_ff),
      .total_cur   (total_ff),
      .ctrl_nxt    (ctrl_step),
      .num_nxt     (num_step),
      .num60_nxt   (num60_step),
      .ovf60_nxt   (ovf60_step),
      .num3600_nxt (num3600_step),
      .ovf3600_nxt (ovf3600_step),
      .total_nxt   (total_step)
   );

   // Parser state: a transfer with tlast hands the state to the finalize
   // stage and starts the next string from the reset state.
   always_comb begin
      ctrl_in    = ctrl_ff;
      num_in     = num_ff;
      num60_in   = num60_ff;
      ovf60_in   = ovf60_ff;
      num3600_in = num3600_ff;
      ovf3600_in = ovf3600_ff;
      total_in   = total_ff;
      if (accept) begin
         num_in     = num_step;
         num60_in   = num60_step;
         ovf60_in   = ovf60_step;
         num3600_in = num3600_step;
         ovf3600_in = ovf3600_step;
         if (req_tlast) begin
            ctrl_in  = '{in_digits: 1'b0, seen_token: 1'b0, status: dtp_pkg::ST_OK};
            total_in = '0;
         end else begin
            ctrl_in  = ctrl_step;
            total_in = total_step;
         end
      end
   end

   always_comb begin
      fin_valid_in = fin_valid_ff;
      fin_ctrl_in  = fin_ctrl_ff;
      fin_total_in = fin_total_ff;
      fin_num60_in = fin_num60_ff;
      fin_ovf60_in = fin_ovf60_ff;
      if (accept && req_tlast) begin
         fin_valid_in = 1'b1;
         fin_ctrl_in  = ctrl_step;
         fin_total_in = total_step;
         fin_num60_in = num60_step;
         fin_ovf60_in = ovf60_step;
      end else if (fin_adv) begin
         fin_valid_in = 1'b0;
      end
   end

   // Finalize: a number still open at the string end counts as minutes.
   assign fin_sum = {1'b0, fin_total_ff} + {1'b0, fin_num60_ff};

   always_comb begin
      fin_status = fin_ctrl_ff.status;
      fin_total  = fin_total_ff;
      if ((fin_ctrl_ff.status == dtp_pkg::ST_OK) && fin_ctrl_ff.in_digits) begin
         if (fin_ovf60_ff || fin_sum[W]) begin
            fin_status = dtp_pkg::ST_OVERFLOW;
         end else begin
            fin_total = fin_sum[W-1:0];
         end
      end
      if ((fin_status == dtp_pkg::ST_OK) && !fin_ctrl_ff.seen_token) begin
         fin_status = dtp_pkg::ST_EMPTY;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;
      if (fin_adv) begin
         rsp_valid_in = fin_valid_ff;
         if (fin_valid_ff) begin
            rsp_status_in = fin_status;
            rsp_total_in  = (fin_status == dtp_pkg::ST_OK) ? TW'(fin_total) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= '{in_digits: 1'b0, seen_token: 1'b0, status: dtp_pkg::ST_OK};
         total_ff     <= '0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctrl_ff      <= ctrl_in;
         total_ff     <= total_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff        <= num_in;
      num60_ff      <= num60_in;
      ovf60_ff      <= ovf60_in;
      num3600_ff    <= num3600_in;
      ovf3600_ff    <= ovf3600_in;
      fin_ctrl_ff   <= fin_ctrl_in;
      fin_total_ff  <= fin_total_in;
      fin_num60_ff  <= fin_num60_in;
      fin_ovf60_ff  <= fin_ovf60_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_total_ff};
   assign rsp_tuser  = rsp_status_ff;

   // A transfer that ends a string always fills the finalize stage.
   a_fin_load: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> fin_valid_ff)
      else $error("finalize stage not loaded at string end");

   // The parser restarts from its reset state after a string end.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (!ctrl_ff.in_digits && !ctrl_ff.seen_token &&
                                 (ctrl_ff.status == dtp_pkg::ST_OK) && (total_ff == '0)))
      else $error("parser state not cleared after string end");

   // A stalled finalize stage keeps its contents.
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && !fin_adv) |=> (fin_valid_ff && $stable(fin_total_ff) &&
                                      $stable(fin_ctrl_ff)))
      else $error("finalize stage lost data under stall");

   // Any error status carries a zero total.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != dtp_pkg::ST_OK)) |-> (rsp_total_ff == '0))
      else $error("nonzero total with error status");

endmodule
